// ===== design/assert_macros.svh =====
// Assertion macros used by the collision resolver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds on each clock edge outside reset
`define ICR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that an implication holds in the cycle after its antecedent
`define ICR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/icr_pkg.sv =====
// Package: types, constants and helpers for the impulse collision resolver
`default_nettype none
package icr_pkg;
  localparam int unsigned VelW  = 32;
  localparam int unsigned NrmW  = 18;
  localparam int unsigned MassW = 31;
  localparam int unsigned BncW  = 17;
  localparam int unsigned PenW  = 31;
  localparam int unsigned CfgW  = 17;
  localparam int unsigned SumW  = 32;
  localparam int unsigned QuotW = 64;
  localparam int unsigned DivW  = 80;
  localparam int unsigned InW   = 4 * VelW + 2 * NrmW + 2 * MassW + 2 * BncW + PenW;
  localparam int unsigned InBW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW  = 8 * 32;

  localparam logic [CfgW-1:0] SlopReset    = 17'd655;
  localparam logic [CfgW-1:0] PercentReset = 17'd65536;
  localparam logic [16:0]     OneQ16       = 17'd65536;

  typedef enum logic [0:0] {
    CFG_SLOP    = 1'b0,
    CFG_PERCENT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_FULL     = 2'd0,
    OUT_SEPARATE = 2'd1,
    OUT_IMMOVE   = 2'd2
  } outcome_t;

  // Per-item control that rides along the pipe
  typedef struct packed {
    logic     vld;
    logic     immov;
    logic     sep;
    logic     nx_neg;
    logic     ny_neg;
  } ctl_t;

  // Held product (a*b)>>16 for a 64 bit a and a 32 bit b, clamped at all ones
  function automatic logic [63:0] sh16_hold(input logic [95:0] p);
    logic [63:0] r;
    if (p[95:80] != '0) r = '1;
    else r = p[79:16];
    return r;
  endfunction

  // Apply sign and clamp to 32 bits; bit 32 flags a clamp
  function automatic logic [32:0] emit(input logic [63:0] mag, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/icr_div.sv =====
// Pipelined restoring divider: one quotient bit per stage
`default_nettype none
module icr_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [icr_pkg::QuotW-1:0] num,
  input  wire logic [icr_pkg::SumW-1:0]  den,
  output logic      [icr_pkg::QuotW-1:0] quo
);
  import icr_pkg::*;
  logic [QuotW-1:0] q_r   [QuotW+1];
  logic [SumW:0]    rem_r [QuotW+1];
  logic [SumW-1:0]  den_r [QuotW+1];

  assign q_r[0]   = num;
  assign rem_r[0] = '0;
  assign den_r[0] = den;

  // Shift one numerator bit into the remainder per stage
  for (genvar i = 0; i < QuotW; i++) begin : g_st
    logic [SumW+1:0] trial;
    logic            fit;
    assign trial = {rem_r[i], q_r[i][QuotW-1]};
    assign fit   = trial >= {2'b00, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= fit ? (SumW+1)'(trial - {2'b00, den_r[i]}) : trial[SumW:0];
        q_r[i+1]   <= {q_r[i][QuotW-2:0], fit};
        den_r[i+1] <= den_r[i];
      end
    end
  end
  assign quo = q_r[QuotW];
endmodule
`default_nettype wire

// ===== design/icr_comp.sv =====
// Pipelined component scaler: scalar*|n|>>16 then *inv_mass>>16, signed and clamped
`default_nettype none
module icr_comp (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [63:0]               scalar,
  input  wire logic [icr_pkg::NrmW-1:0]  nmag,
  input  wire logic [icr_pkg::MassW-1:0] imass,
  input  wire logic                      neg,
  output logic      [32:0]               res
);
  import icr_pkg::*;
  logic [63:0] t_r;
  logic [MassW-1:0] im_r;
  logic neg_r, neg2_r, neg3_r;
  logic [62:0] plo_r, phi_r;
  logic [95:0] p2_r;
  logic [32:0] res_r;

  // Stage one: scale by normal magnitude; stages two and three: by inverse mass
  // in two 32 bit halves; stage four: sign and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= sh16_hold({32'd0, scalar} * {78'd0, nmag});
      im_r   <= imass;
      neg_r  <= neg;
      plo_r  <= {31'd0, t_r[31:0]} * {32'd0, im_r};
      phi_r  <= {31'd0, t_r[63:32]} * {32'd0, im_r};
      neg2_r <= neg_r;
      p2_r   <= {33'd0, plo_r} + {1'd0, phi_r, 32'd0};
      neg3_r <= neg2_r;
      res_r  <= emit(sh16_hold(p2_r), neg3_r);
    end
  end
  assign res = res_r;
endmodule
`default_nettype wire

// ===== design/impulse_collision_resolve.sv =====
// Top level: 2D impulse collision resolver pipeline
// Throughput: one item per cycle; a stall on the output freezes the whole pipe.
// Critical path: one quotient bit of the 64 stage divider, or one 64x18 product.
// Reset: rst_n synchronous active low clears valid bits and loads register resets.
`default_nettype none
`include "assert_macros.svh"
module impulse_collision_resolve (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y, inv_mass_a,
  // inv_mass_b, bounce_a, bounce_b, penetration
  input  wire logic [icr_pkg::InBW-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // dvel_a_x, dvel_a_y, dvel_b_x, dvel_b_y, dpos_a_x, dpos_a_y, dpos_b_x, dpos_b_y
  output logic      [icr_pkg::OutW-1:0] out_tdata,
  // outcome, saturated
  output logic      [2:0]               out_tuser,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [31:0]              cfg_data
);
  import icr_pkg::*;
  localparam int unsigned Lat = 75;

  logic [CfgW-1:0] slop_r, pct_r;
  logic en;
  ctl_t ctl_r [Lat+1];

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slop_r <= SlopReset;
      pct_r  <= PercentReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SLOP:    slop_r <= cfg_data[CfgW-1:0];
        CFG_PERCENT: pct_r  <= cfg_data[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack input fields
  logic signed [VelW-1:0] vax, vay, vbx, vby;
  logic signed [NrmW-1:0] nx, ny;
  logic [MassW-1:0] ima, imb;
  logic [BncW-1:0] ba, bb;
  logic [PenW-1:0] pen;
  assign vax = in_tdata[31:0];
  assign vay = in_tdata[63:32];
  assign vbx = in_tdata[95:64];
  assign vby = in_tdata[127:96];
  assign nx  = in_tdata[145:128];
  assign ny  = in_tdata[163:146];
  assign ima = in_tdata[194:164];
  assign imb = in_tdata[225:195];
  assign ba  = in_tdata[242:226];
  assign bb  = in_tdata[259:243];
  assign pen = in_tdata[290:260];

  // Stage 1: velocity differences, normal magnitudes, sum, excess, restitution
  logic signed [VelW:0] dx_r, dy_r;
  logic signed [NrmW-1:0] nx_r, ny_r;
  logic [SumW-1:0] sum_r;
  logic [PenW-1:0] exc_r;
  logic [16:0] e_r;
  logic [MassW-1:0] ima_r [Lat+1];
  logic [MassW-1:0] imb_r [Lat+1];
  logic [NrmW-1:0] nxm_r [Lat+1];
  logic [NrmW-1:0] nym_r [Lat+1];
  // Stage 2: products; stage 3: dot; stage 4: impulse numerator
  logic signed [VelW+NrmW:0] px_r, py_r;
  logic signed [VelW+NrmW+1:0] dot_r;
  logic [16:0] e2_r, e3_r;
  logic [SumW-1:0] sum2_r, sum3_r, sum4_r, sum5_r;
  logic [PenW-1:0] exc2_r, exc3_r, exc4_r, exc5_r;
  logic [95:0] jn_r;
  logic [63:0] jn4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= (VelW+1)'(vbx) - (VelW+1)'(vax);
      dy_r  <= (VelW+1)'(vby) - (VelW+1)'(vay);
      nx_r  <= nx;
      ny_r  <= ny;
      sum_r <= SumW'(ima) + SumW'(imb);
      exc_r <= ({1'b0, pen} > {15'd0, slop_r}) ? PenW'({1'b0, pen} - {15'd0, slop_r}) : '0;
      e_r   <= (ba < bb) ? ba : bb;
      ima_r[0] <= ima;
      imb_r[0] <= imb;
      nxm_r[0] <= nx[NrmW-1] ? NrmW'(-nx) : NrmW'(nx);
      nym_r[0] <= ny[NrmW-1] ? NrmW'(-ny) : NrmW'(ny);
      px_r  <= (VelW+NrmW+1)'(dx_r * nx_r);
      py_r  <= (VelW+NrmW+1)'(dy_r * ny_r);
      e2_r  <= e_r; sum2_r <= sum_r; exc2_r <= exc_r;
      dot_r <= (VelW+NrmW+2)'(px_r) + (VelW+NrmW+2)'(py_r);
      e3_r  <= e2_r; sum3_r <= sum2_r; exc3_r <= exc2_r;
      jn_r  <= (dot_r > 0) ? '0 : 96'(64'(-dot_r)) * {78'd0, 18'(OneQ16) + 18'(e3_r)};
      sum4_r <= sum3_r; exc4_r <= exc3_r;
      jn4_r <= sh16_hold(jn_r);
      sum5_r <= sum4_r; exc5_r <= exc4_r;
    end
  end

  // Delay side data to the divider outputs and the scalers
  for (genvar i = 0; i < Lat; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        ima_r[i+1] <= ima_r[i];
        imb_r[i+1] <= imb_r[i];
        nxm_r[i+1] <= nxm_r[i];
        nym_r[i+1] <= nym_r[i];
      end
    end
  end

  // Control pipe
  ctl_t c_in;
  ctl_t c3;
  always_comb begin
    c_in.vld    = in_tvalid;
    c_in.immov  = (ima == '0) && (imb == '0);
    c_in.sep    = 1'b0;
    c_in.nx_neg = nx[NrmW-1];
    c_in.ny_neg = ny[NrmW-1];
  end
  // Mark separating once the dot product is known
  always_comb begin
    c3     = ctl_r[2];
    c3.sep = dot_r > 0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Lat; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl_r[0] <= c_in;
      for (int i = 0; i < Lat; i++) begin
        if (i == 2) ctl_r[i+1] <= c3;
        else ctl_r[i+1] <= ctl_r[i];
      end
    end
  end

  // Dividers start at stage 5
  logic [63:0] jq, sq;
  icr_div u_div_j (.clk, .en, .num(jn4_r), .den(sum5_r), .quo(jq));
  icr_div u_div_s (.clk, .en, .num({17'd0, exc5_r, 16'd0}), .den(sum5_r), .quo(sq));

  // Stage after divide: scale correction by percent; hold j alongside
  logic [63:0] j2_r, s2_r;
  logic [95:0] sp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r <= {32'd0, sq} * {79'd0, pct_r};
      j2_r <= jq;
      s2_r <= sh16_hold(sp_r);
    end
  end
  logic [63:0] j3_r;
  always_ff @(posedge clk) if (en) j3_r <= j2_r;

  // Component scalers (index at stage 71)
  localparam int unsigned Ci = 70;
  logic [32:0] r [8];
  icr_comp u_c0 (.clk, .en, .scalar(j3_r), .nmag(nxm_r[Ci]), .imass(ima_r[Ci]),
                 .neg(!ctl_r[Ci].nx_neg), .res(r[0]));
  icr_comp u_c1 (.clk, .en, .scalar(j3_r), .nmag(nym_r[Ci]), .imass(ima_r[Ci]),
                 .neg(!ctl_r[Ci].ny_neg), .res(r[1]));
  icr_comp u_c2 (.clk, .en, .scalar(j3_r), .nmag(nxm_r[Ci]), .imass(imb_r[Ci]),
                 .neg(ctl_r[Ci].nx_neg), .res(r[2]));
  icr_comp u_c3 (.clk, .en, .scalar(j3_r), .nmag(nym_r[Ci]), .imass(imb_r[Ci]),
                 .neg(ctl_r[Ci].ny_neg), .res(r[3]));
  icr_comp u_c4 (.clk, .en, .scalar(s2_r), .nmag(nxm_r[Ci]), .imass(ima_r[Ci]),
                 .neg(!ctl_r[Ci].nx_neg), .res(r[4]));
  icr_comp u_c5 (.clk, .en, .scalar(s2_r), .nmag(nym_r[Ci]), .imass(ima_r[Ci]),
                 .neg(!ctl_r[Ci].ny_neg), .res(r[5]));
  icr_comp u_c6 (.clk, .en, .scalar(s2_r), .nmag(nxm_r[Ci]), .imass(imb_r[Ci]),
                 .neg(ctl_r[Ci].nx_neg), .res(r[6]));
  icr_comp u_c7 (.clk, .en, .scalar(s2_r), .nmag(nym_r[Ci]), .imass(imb_r[Ci]),
                 .neg(ctl_r[Ci].ny_neg), .res(r[7]));

  // Output register: all zero for immovable cases; velocity terms zero for separating cases
  ctl_t co;
  logic [OutW-1:0] od;
  logic sat;
  logic [1:0] oc;
  always_comb begin
    co = ctl_r[Lat-1];
    od = '0;
    sat = 1'b0;
    oc = OUT_FULL;
    if (co.immov) begin
      oc = OUT_IMMOVE;
    end else begin
      if (co.sep) oc = OUT_SEPARATE;
      for (int k = 0; k < 8; k++) begin
        if (!(co.sep && k < 4)) begin
          od[k*32 +: 32] = r[k][31:0];
          sat = sat | r[k][32];
        end
      end
    end
  end
  assign out_tvalid = ctl_r[Lat].vld;
  logic [OutW-1:0] od_r;
  logic [2:0] ou_r;
  always_ff @(posedge clk) if (en) begin
    od_r <= od;
    ou_r <= {sat, oc};
  end
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  `ICR_ASSERT_IMP(a_stall_hold, out_tvalid && !out_tready, !in_tready, "stall not propagated")
  `ICR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                   "output changed under stall")
  `ICR_ASSERT_IMP(a_immov_zero, out_tvalid && out_tuser[1:0] == OUT_IMMOVE,
                  out_tdata == '0 && !out_tuser[2], "immovable result not zero")
endmodule
`default_nettype wire

// ===== tb/sv/impulse_collision_resolve_tb.sv =====
// Testbench for impulse_collision_resolve: stream stimulus, contact predictor, result checks
`timescale 1ns / 1ps
module impulse_collision_resolve_tb;
  import icr_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned Drain      = 100;

  typedef struct packed {
    logic [7:0][31:0] val;
    logic [1:0]       outcome;
    logic             sat;
  } contact_res_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InBW-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutW-1:0]     out_tdata;
  logic [2:0]          out_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [0:0]          cfg_index;
  logic [31:0]         cfg_data;

  logic [InBW-1:0]     pend_items[$];
  contact_res_t        expect_res[$];
  logic [16:0]         slop_q;
  logic [16:0]         pct_q;
  logic                quiet;
  int                  in_cnt;
  int                  out_cnt;
  int                  errors;
  int                  sender_gap;
  int                  recv_gap;
  int                  hold_left;
  logic                hold_done;
  int                  stall_cnt;

  impulse_collision_resolve u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (a * b) >> 16, held at all ones when it does not fit in 64 bits
  function automatic logic [63:0] mul_q16(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:80] != '0) return '1;
    return p[79:16];
  endfunction

  // Scale along one normal axis by one inverse mass, sign, clamp
  function automatic logic [31:0] axis_term(input logic [63:0] scalar, input longint n,
                                            input logic [63:0] im, input logic for_a,
                                            inout logic sat);
    logic [63:0] nmag;
    logic [63:0] t;
    logic        neg;
    nmag = (n < 0) ? 64'(-n) : 64'(n);
    t = mul_q16(mul_q16(scalar, nmag), im);
    neg = (n < 0) != for_a;
    if (neg) begin
      if (t > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(64'd0 - t);
    end
    if (t > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return t[31:0];
  endfunction

  // Resolve one contact item with the current register values
  function automatic contact_res_t resolve_contact(input logic [InBW-1:0] d);
    contact_res_t r;
    longint      dvx, dvy, nx, ny, dot;
    logic [63:0] ima, imb, sum, e, j, excess, s;
    logic [63:0] pen;
    logic        sat;
    r = '0;
    sat = 1'b0;
    dvx = longint'($signed(d[95:64])) - longint'($signed(d[31:0]));
    dvy = longint'($signed(d[127:96])) - longint'($signed(d[63:32]));
    nx  = longint'($signed(d[145:128]));
    ny  = longint'($signed(d[163:146]));
    ima = 64'(d[194:164]);
    imb = 64'(d[225:195]);
    pen = 64'(d[290:260]);
    sum = ima + imb;
    if (sum == 0) begin
      r.outcome = OUT_IMMOVE;
      return r;
    end
    dot = dvx * nx + dvy * ny;
    if (dot > 0) begin
      r.outcome = OUT_SEPARATE;
    end else begin
      r.outcome = OUT_FULL;
      e = (d[242:226] < d[259:243]) ? 64'(d[242:226]) : 64'(d[259:243]);
      j = mul_q16(64'(-dot), 64'(OneQ16) + e) / sum;
      r.val[0] = axis_term(j, nx, ima, 1'b1, sat);
      r.val[1] = axis_term(j, ny, ima, 1'b1, sat);
      r.val[2] = axis_term(j, nx, imb, 1'b0, sat);
      r.val[3] = axis_term(j, ny, imb, 1'b0, sat);
    end
    excess = (pen > 64'(slop_q)) ? pen - 64'(slop_q) : 64'd0;
    s = mul_q16((excess << 16) / sum, 64'(pct_q));
    r.val[4] = axis_term(s, nx, ima, 1'b1, sat);
    r.val[5] = axis_term(s, ny, ima, 1'b1, sat);
    r.val[6] = axis_term(s, nx, imb, 1'b0, sat);
    r.val[7] = axis_term(s, ny, imb, 1'b0, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [InBW-1:0] pack_contact(
      input logic [31:0] vax, input logic [31:0] vay, input logic [31:0] vbx,
      input logic [31:0] vby, input logic [17:0] nx, input logic [17:0] ny,
      input logic [30:0] ima, input logic [30:0] imb, input logic [16:0] ba,
      input logic [16:0] bb, input logic [30:0] pen);
    return InBW'({pen, bb, ba, imb, ima, ny, nx, vby, vbx, vay, vax});
  endfunction

  // Random contact: mostly physical sizes, some full-width noise
  function automatic logic [InBW-1:0] rand_contact();
    logic [31:0] v[4];
    logic [17:0] nx, ny;
    logic [30:0] ima, imb, pen;
    int          k;
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) v[k] = $urandom();
      else v[k] = 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
    end
    case ($urandom_range(0, 4))
      0: begin
        nx = 18'($urandom());
        ny = 18'($urandom());
      end
      1: begin
        nx = ($urandom_range(0, 1) != 0) ? 18'sd65536 : -18'sd65536;
        ny = '0;
      end
      default: begin
        nx = 18'($signed($urandom_range(0, 131072)) - 65536);
        ny = 18'($signed($urandom_range(0, 131072)) - 65536);
      end
    endcase
    case ($urandom_range(0, 5))
      0: ima = '0;
      1: ima = 31'($urandom());
      default: ima = 31'($urandom_range(1, 1 << 18));
    endcase
    case ($urandom_range(0, 5))
      0: imb = '0;
      1: imb = 31'($urandom());
      default: imb = 31'($urandom_range(1, 1 << 18));
    endcase
    case ($urandom_range(0, 3))
      0: pen = 31'($urandom());
      1: pen = 31'($urandom_range(0, 1000));
      default: pen = 31'($urandom_range(0, 1 << 20));
    endcase
    return pack_contact(v[0], v[1], v[2], v[3], nx, ny, ima, imb,
                        17'($urandom()), 17'($urandom()), pen);
  endfunction

  // Write one register; only called while the block is idle
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SLOP) slop_q = value[16:0];
    else pct_q = value[16:0];
  endtask

  // Hold until every expected result is out, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk); while (pend_items.size() != 0 || expect_res.size() != 0);
    repeat (Drain) @(posedge clk);
  endtask

  // Driver: present pending items, predict each accepted one
  always @(posedge clk) begin
    logic            nxt_valid;
    logic [InBW-1:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      sender_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expect_res.push_back(resolve_contact(in_tdata));
        void'(pend_items.pop_front());
        in_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (pend_items.size() != 0) begin
          if (!quiet && hold_left == 0 && $urandom_range(0, 9) == 0) begin
            sender_gap = $urandom_range(1, 19);
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = pend_items[0];
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // Monitor: drive ready with stalls, compare each result with the oldest expectation
  always @(posedge clk) begin
    contact_res_t exp_r;
    logic         nxt_ready;
    int           k;
    nxt_ready = 1'b1;
    if (!rst_n) begin
      recv_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        out_cnt++;
        if (expect_res.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          exp_r = expect_res.pop_front();
          for (k = 0; k < 8; k++) begin
            if (out_tdata[k*32 +: 32] !== exp_r.val[k]) begin
              $error("%s: expected %h, actual %h",
                     k == 0 ? "dvel_a_x" : k == 1 ? "dvel_a_y" : k == 2 ? "dvel_b_x" :
                     k == 3 ? "dvel_b_y" : k == 4 ? "dpos_a_x" : k == 5 ? "dpos_a_y" :
                     k == 6 ? "dpos_b_x" : "dpos_b_y", exp_r.val[k], out_tdata[k*32 +: 32]);
              errors++;
            end
          end
          if (out_tuser[1:0] !== exp_r.outcome) begin
            $error("outcome: expected %0d, actual %0d", exp_r.outcome, out_tuser[1:0]);
            errors++;
          end
          if (out_tuser[2] !== exp_r.sat) begin
            $error("saturated: expected %0d, actual %0d", exp_r.sat, out_tuser[2]);
            errors++;
          end
        end
      end
      // Long hold-off once, so the pipe fills and backs up the input
      if (!hold_done && in_cnt >= 500) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 19);
        nxt_ready = 1'b0;
      end
    end
    out_tready <= nxt_ready;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) ||
        (pend_items.size() == 0 && expect_res.size() == 0 && !cfg_valid)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("impulse_collision_resolve test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int          ph, k;
    logic [31:0] slop_w[5];
    logic [31:0] pct_w[5];
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    quiet      = 1'b0;
    in_cnt     = 0;
    out_cnt    = 0;
    errors     = 0;
    stall_cnt  = 0;
    slop_q     = SlopReset;
    pct_q      = PercentReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed contacts under reset register values
    // both immovable
    pend_items.push_back(pack_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 18'sd65536, 18'sd0, 31'd0, 31'd0,
                         17'h1FFFF, 17'h1FFFF, 31'h7FFF_FFFF));
    // head-on, unit normal, equal masses
    pend_items.push_back(pack_contact(32'h0001_0000, 32'd0, 32'hFFFF_0000, 32'd0,
                         18'sd65536, 18'sd0, 31'd65536, 31'd65536,
                         17'd32768, 17'd65536, 31'd6553));
    // separating, penetration still corrected
    pend_items.push_back(pack_contact(32'hFFFF_0000, 32'd0, 32'h0001_0000, 32'd0,
                         18'sd65536, 18'sd0, 31'd65536, 31'd131072,
                         17'd0, 17'd0, 31'd200000));
    // resting contact, dot exactly zero
    pend_items.push_back(pack_contact(32'd5, 32'd9, 32'd5, 32'd9, 18'sd0, -18'sd65536,
                         31'd65536, 31'd65536, 17'd65536, 17'd65536, 31'd655));
    // shallow penetration just at and just above the slop
    pend_items.push_back(pack_contact(32'd0, 32'd0, 32'd0, 32'hFFF0_0000, 18'sd0,
                         18'sd65536, 31'd65536, 31'd0, 17'd100, 17'd200, 31'd655));
    pend_items.push_back(pack_contact(32'd0, 32'd0, 32'd0, 32'hFFF0_0000, 18'sd0,
                         18'sd65536, 31'd0, 31'd65536, 17'd100, 17'd200, 31'd656));
    // extreme velocities and masses, saturating both ways
    pend_items.push_back(pack_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 18'sd65536, 18'sd65536, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 31'h7FFF_FFFF));
    pend_items.push_back(pack_contact(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, -18'sd65536, -18'sd65536, 31'd1,
                         31'h7FFF_FFFF, 17'd0, 17'h1FFFF, 31'h7FFF_FFFF));
    // non-unit normals at the field extremes
    pend_items.push_back(pack_contact(32'h0010_0000, 32'hFFF0_0000, 32'd0, 32'd0,
                         18'h20000, 18'h1FFFF, 31'd65536, 31'd65536,
                         17'h1FFFF, 17'h1FFFF, 31'd1 << 20));
    pend_items.push_back(pack_contact(32'd0, 32'd0, 32'h0010_0000, 32'h0010_0000,
                         18'h1FFFF, 18'h20000, 31'd3, 31'd7, 17'd1, 17'd0, 31'd1 << 24));
    // tiny masses, one body immovable
    pend_items.push_back(pack_contact(32'h0002_0000, 32'h0003_0000, 32'd0, 32'd0,
                         18'sd46341, 18'sd46341, 31'd1, 31'd0, 17'd65536, 17'd0, 31'd0));
    pend_items.push_back(pack_contact(32'h0002_0000, 32'h0003_0000, 32'd0, 32'd0,
                         -18'sd46341, 18'sd46341, 31'd0, 31'd1, 17'd65536, 17'd65536,
                         31'h7FFF_FFFF));
    for (k = 0; k < 8; k++) pend_items.push_back(rand_contact());
    wait_idle();

    // Register settings, extremes among them, then random contacts in each
    slop_w[0] = 32'd0;            pct_w[0] = 32'd0;
    slop_w[1] = 32'd65536;        pct_w[1] = 32'd65536;
    slop_w[2] = 32'hFFFF_FFFF;    pct_w[2] = 32'hFFFE_FFFF;
    slop_w[3] = $urandom();       pct_w[3] = $urandom();
    slop_w[4] = 32'd655;          pct_w[4] = 32'd52429;
    for (ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SLOP, slop_w[ph]);
      write_reg(CFG_PERCENT, pct_w[ph]);
      if (ph == 4) quiet = 1'b1;
      for (k = 0; k < 280; k++) pend_items.push_back(rand_contact());
      wait_idle();
    end

    $display("covered %0d contacts over 6 register settings, %0d results checked",
             in_cnt, out_cnt);
    if (errors == 0) begin
      $display("impulse_collision_resolve test passed");
    end else begin
      $display("impulse_collision_resolve test failed");
    end
    $finish;
  end
endmodule
